// ===== rtl/fq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fq_pkg;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE    = 3'd0,
    OP_DEQUEUE    = 3'd1,
    OP_PEEK_FRONT = 3'd2,
    OP_PEEK_REAR  = 3'd3,
    OP_READ_AT    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/fq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fifo_queue_with_peek_and_index.sv =====
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------
// request  | in        | in_valid_i/in_stall_o | operation_i, value_i, position_i
// result   | out       | out_valid_o/out_stall_i | data_out_o, status_o, occupancy_o
//
// One transaction per cycle is sustained while out_stall_i is low; a result is
// valid once its request has passed the read stage (entry RAM read and status load
// at the accepting edge) and then the output register.
// Pointers and count update at acceptance, so a read right after an enqueue
// sees the new word through the RAM without forwarding.
// Reset clears head, tail and count; the entry RAM is not cleared.
// A stalled result holds the read stage; requests stall once both are full.
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_with_peek_and_index #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [fq_pkg::OP_W-1:0]            operation_i,
  input  wire logic signed [fq_pkg::VAL_W-1:0]    value_i,
  input  wire logic [fq_pkg::POS_W-1:0]           position_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [fq_pkg::VAL_W-1:0]         data_out_o,
  output fq_pkg::status_e                         status_o,
  output logic [$clog2(DEPTH+1)-1:0]              occupancy_o
);

  import fq_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // read stage
  logic          s1_valid_q;
  logic          s1_rd_q;
  status_e       s1_status_q;
  logic [CW-1:0] s1_occ_q;

  // output register
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_data_q;
  status_e                 out_status_q;
  logic [CW-1:0]           out_occ_q;

  logic          accept;
  logic          s1_adv;
  status_e       status_d;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] head_inc, tail_inc, rear_addr, at_addr;
  logic [SW-1:0] at_sum;

  logic signed [DATA_WIDTH-1:0] rdata;
  logic signed [DATA_WIDTH-1:0] wdata;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign tail_inc  = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
  assign rear_addr = (tail_q == '0) ? AW'(DEPTH - 1) : tail_q - AW'(1);

  // head + position stays below 2*DEPTH whenever position is in range
  assign at_sum  = SW'(head_q) + SW'(position_i);
  assign at_addr = (at_sum >= SW'(DEPTH)) ? AW'(at_sum - SW'(DEPTH)) : AW'(at_sum);

  assign wdata = DATA_WIDTH'(value_i);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    status_d = ST_OK;
    rd_en    = 1'b0;
    raddr    = head_q;
    we       = 1'b0;
    case (op_e'(operation_i))
      OP_ENQUEUE: begin
        if (cnt_q == CW'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          we     = 1'b1;
          tail_d = tail_inc;
          cnt_d  = cnt_q + CW'(1);
        end
      end
      OP_DEQUEUE: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en  = 1'b1;
          head_d = head_inc;
          cnt_d  = cnt_q - CW'(1);
        end
      end
      OP_PEEK_FRONT: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en = 1'b1;
        end
      end
      OP_PEEK_REAR: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en = 1'b1;
          raddr = rear_addr;
        end
      end
      OP_READ_AT: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else if (CMP_W'(position_i) >= CMP_W'(cnt_q)) begin
          status_d = ST_RANGE;
        end else begin
          rd_en = 1'b1;
          raddr = at_addr;
        end
      end
      default: begin
      end
    endcase
  end

  fq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && we),
    .waddr_i (tail_q),
    .wdata_i (wdata),
    .re_i    (accept && rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q <= head_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q     <= rd_en;
      s1_status_q <= status_d;
      s1_occ_q    <= cnt_d;
    end
    if (s1_adv) begin
      out_data_q   <= s1_rd_q ? VAL_W'(rdata) : '0;
      out_status_q <= s1_status_q;
      out_occ_q    <= s1_occ_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign status_o    = out_status_q;
  assign occupancy_o = out_occ_q;

endmodule

`default_nettype wire

// ===== rtl/fq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fq_checker #(
  parameter int DEPTH = 16
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic [fq_pkg::OP_W-1:0]          operation_i,
  input wire logic signed [fq_pkg::VAL_W-1:0]  value_i,
  input wire logic [fq_pkg::POS_W-1:0]         position_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic signed [fq_pkg::VAL_W-1:0]  data_out_o,
  input wire fq_pkg::status_e                  status_o,
  input wire logic [$clog2(DEPTH+1)-1:0]       occupancy_o
);

  import fq_pkg::*;

  // a held request keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(operation_i)
      && $stable(value_i) && $stable(position_i))
    else $error("request changed while stalled");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_out_o)
      && $stable(status_o) && $stable(occupancy_o))
    else $error("result changed while stalled");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("occupancy above depth");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> data_out_o == '0)
    else $error("nonzero data on error status");

  // full and empty refusals leave the count at its limit
  a_status_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != ST_FULL || occupancy_o == ($clog2(DEPTH+1))'(DEPTH))
      && (status_o != ST_EMPTY || occupancy_o == '0)
      && (status_o != ST_RANGE || occupancy_o != '0))
    else $error("status disagrees with occupancy");

endmodule

bind fifo_queue_with_peek_and_index fq_checker #(.DEPTH(DEPTH)) u_fq_checker (.*);

`default_nettype wire
